/* hw/rtl/pfba_pkg.sv */
`timescale 1ns / 1ps

package pfba_pkg;

  localparam int WORD_W   = 64;
  localparam int BIT_W    = 6;
  localparam int KB_SHIFT = 10;
  localparam int KB_W     = 22;
  localparam int RSV_W    = 17;
  localparam int FRAME_W  = 16;
  localparam int DVD_W    = KB_W + KB_SHIFT;
  localparam int QUO_W    = DVD_W - KB_SHIFT;
  localparam int BND_W    = QUO_W + 1;

  localparam int DEF_FRAME_COUNT = 65536;
  localparam int DEF_PAGE_BYTES  = 4096;

  typedef enum logic [1:0] {
    ACT_INIT  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  localparam logic CFG_MEM_KB = 1'b0;
  localparam logic CFG_RSV    = 1'b1;

  function automatic logic [BIT_W:0] span_rel(logic [BND_W-1:0] bound,
                                               logic [BND_W-1:0] base);
    logic [BND_W:0] diff;
    logic [BIT_W:0] k;
    diff = {1'b0, bound} - {1'b0, base};
    if (diff[BND_W]) begin
      k = '0;
    end else if (diff[BND_W-1:0] >= BND_W'(WORD_W)) begin
      k = (BIT_W+1)'(WORD_W);
    end else begin
      k = diff[BIT_W:0];
    end
    return k;
  endfunction

  function automatic logic [WORD_W-1:0] low_mask(logic [BIT_W:0] k);
    logic [WORD_W-1:0] m;
    for (int i = 0; i < WORD_W; i++) begin
      m[i] = ((BIT_W+1)'(i) < k);
    end
    return m;
  endfunction

endpackage

/* hw/rtl/page_frame_bitmap_allocator_unit.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Payload
// request   in         in_valid_i/in_stall_o   action_i, frame_in_i
// result    out        out_valid_o/out_stall_i frame_out_o, ok_o
// config    in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// The map is held as 64-bit words, W = ceil(FRAME_COUNT/8*8 / 64) words, one RAM port each way.
// in_stall_o falls in the same cycle in which out_valid_o rises, so the next request can enter then.
// Init: one shift step for the frame limit, then W word writes.
// Allocate: pipelined word scan that stops at the first word with a free bit.
// Release: read-modify-write. Unused action or out-of-range release: straight to the result.
// After reset a clearing pass sets every word to used; requests stall meanwhile.
// A held result stalls the block only at its final step; the next request enters once it moves.

module page_frame_bitmap_allocator_unit
  import pfba_pkg::*;
#(
  parameter int FRAME_COUNT = DEF_FRAME_COUNT,
  parameter int PAGE_BYTES  = DEF_PAGE_BYTES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic [FRAME_W-1:0] frame_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [FRAME_W-1:0] frame_out_o,
  output logic               ok_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [KB_W-1:0]    cfg_data_i
);

  localparam int MAP_FRAMES = (FRAME_COUNT / 8) * 8;
  localparam int WORDS      = (MAP_FRAMES + WORD_W - 1) / WORD_W;
  localparam int AW         = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CW         = $clog2(WORDS + 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SWEEP,
    ST_SCAN,
    ST_REL_RD,
    ST_REL_WR,
    ST_RESP
  } state_e;

  state_e             state_q;
  logic [CW-1:0]      sw_q;
  logic [CW-1:0]      chk_q;
  logic               rd_pend_q;
  logic [BND_W-1:0]   r_q;
  logic [BND_W-1:0]   f_q;
  logic [FRAME_W-1:0] res_frame_q;
  logic               res_ok_q;
  logic [AW-1:0]      rel_addr_q;
  logic [BIT_W-1:0]   rel_bit_q;
  logic               out_vld_q;
  logic [FRAME_W-1:0] out_frame_q;
  logic               out_ok_q;
  logic [KB_W-1:0]    mem_kb_q;
  logic [RSV_W-1:0]   rsv_q;

  logic               in_acc;
  action_e            act;
  logic               div_start;
  logic               div_done;
  logic [QUO_W-1:0]   div_quot;
  logic [BND_W-1:0]   q_ext;
  logic [BND_W-1:0]   lim;
  logic [BND_W-1:0]   f_new;
  logic [BND_W-1:0]   rsv_ext;
  logic [BND_W-1:0]   r_new;
  logic [BND_W-1:0]   fr_in;
  logic               fr_ok;
  logic [BND_W-1:0]   base;
  logic [WORD_W-1:0]  sweep_word;
  logic               sw_last;
  logic               chk_last;
  logic               scan_rd;
  logic [WORD_W-1:0]  rd_data;
  logic               word_full;
  logic [BIT_W-1:0]   fz_idx;
  logic [BND_W-1:0]   found;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic               out_load;

  assign in_acc    = in_valid_i && (state_q == ST_IDLE);
  assign act       = action_e'(action_i);
  assign div_start = in_acc && (act == ACT_INIT);
  assign out_load  = (state_q == ST_RESP) && (!out_vld_q || !out_stall_i);

  pfba_div #(
    .DIVISOR(PAGE_BYTES)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i({mem_kb_q, KB_SHIFT'(0)}),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  always_comb begin
    q_ext   = BND_W'(div_quot);
    lim     = (q_ext > BND_W'(FRAME_COUNT)) ? BND_W'(FRAME_COUNT) : q_ext;
    f_new   = {lim[BND_W-1:3], 3'b000};
    rsv_ext = BND_W'(rsv_q);
    r_new   = (rsv_ext > BND_W'(FRAME_COUNT)) ? BND_W'(FRAME_COUNT) : rsv_ext;
    fr_in   = BND_W'(frame_in_i);
    fr_ok   = (fr_in < BND_W'(MAP_FRAMES));
  end

  always_comb begin
    base       = BND_W'({sw_q[AW-1:0], BIT_W'(0)});
    sweep_word = low_mask(span_rel(r_q, base)) | ~low_mask(span_rel(f_q, base));
    sw_last    = (sw_q == CW'(WORDS - 1));
    chk_last   = (chk_q == CW'(WORDS - 1));
    scan_rd    = (state_q == ST_SCAN) && (sw_q < CW'(WORDS));
  end

  always_comb begin
    word_full = &rd_data;
    fz_idx    = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!rd_data[i]) begin
        fz_idx = BIT_W'(i);
      end
    end
    found = BND_W'({chk_q[AW-1:0], fz_idx});
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sw_q[AW-1:0];
    mem_wdata = sweep_word;
    mem_re    = 1'b0;
    mem_raddr = sw_q[AW-1:0];
    unique case (state_q)
      ST_CLEAR, ST_SWEEP: begin
        mem_we = 1'b1;
      end
      ST_SCAN: begin
        mem_re    = scan_rd;
        mem_we    = rd_pend_q && !word_full;
        mem_waddr = chk_q[AW-1:0];
        mem_wdata = rd_data | (WORD_W'(1) << fz_idx);
      end
      ST_REL_RD: begin
        mem_re    = 1'b1;
        mem_raddr = rel_addr_q;
      end
      ST_REL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = rel_addr_q;
        mem_wdata = rd_data & ~(WORD_W'(1) << rel_bit_q);
      end
      ST_IDLE, ST_DIV, ST_RESP: begin
        mem_we = 1'b0;
      end
    endcase
  end

  pfba_map #(
    .WORDS(WORDS),
    .AW   (AW)
  ) u_map (
    .clk_i    (clk_i),
    .wr_en_i  (mem_we),
    .wr_addr_i(mem_waddr),
    .wr_data_i(mem_wdata),
    .rd_en_i  (mem_re),
    .rd_addr_i(mem_raddr),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      sw_q        <= '0;
      chk_q       <= '0;
      rd_pend_q   <= 1'b0;
      r_q         <= '0;
      f_q         <= '0;
      res_frame_q <= '0;
      res_ok_q    <= 1'b0;
      rel_addr_q  <= '0;
      rel_bit_q   <= '0;
      out_vld_q   <= 1'b0;
      out_frame_q <= '0;
      out_ok_q    <= 1'b0;
      mem_kb_q    <= '0;
      rsv_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_MEM_KB) begin
          mem_kb_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_RSV) begin
          rsv_q <= cfg_data_i[RSV_W-1:0];
        end
      end
      if (out_load) begin
        out_vld_q   <= 1'b1;
        out_frame_q <= res_frame_q;
        out_ok_q    <= res_ok_q;
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          if (sw_last) begin
            sw_q    <= '0;
            state_q <= ST_IDLE;
          end else begin
            sw_q <= sw_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            res_frame_q <= '0;
            sw_q        <= '0;
            rd_pend_q   <= 1'b0;
            unique case (act)
              ACT_INIT: begin
                r_q      <= r_new;
                res_ok_q <= 1'b1;
                state_q  <= ST_DIV;
              end
              ACT_ALLOC: begin
                res_ok_q <= 1'b0;
                state_q  <= ST_SCAN;
              end
              ACT_FREE: begin
                rel_addr_q <= fr_in[BIT_W +: AW];
                rel_bit_q  <= fr_in[BIT_W-1:0];
                res_ok_q   <= fr_ok;
                state_q    <= fr_ok ? ST_REL_RD : ST_RESP;
              end
              ACT_NOP: begin
                res_ok_q <= 1'b0;
                state_q  <= ST_RESP;
              end
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            f_q     <= f_new;
            state_q <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          sw_q <= sw_q + 1'b1;
          if (sw_last) begin
            state_q <= ST_RESP;
          end
        end
        ST_SCAN: begin
          if (scan_rd) begin
            sw_q <= sw_q + 1'b1;
          end
          rd_pend_q <= scan_rd;
          chk_q     <= sw_q;
          if (rd_pend_q) begin
            if (!word_full) begin
              res_frame_q <= found[FRAME_W-1:0];
              res_ok_q    <= 1'b1;
              state_q     <= ST_RESP;
            end else if (chk_last) begin
              state_q <= ST_RESP;
            end
          end
        end
        ST_REL_RD: begin
          state_q <= ST_REL_WR;
        end
        ST_REL_WR: begin
          state_q <= ST_RESP;
        end
        ST_RESP: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign frame_out_o = out_frame_q;
  assign ok_o        = out_ok_q;

`ifndef SYNTHESIS
  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted without entering a busy state");

  a_fail_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> frame_out_o == '0)
    else $error("failed result carries a nonzero frame");

  a_port_no_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("map read and write hit the same word");
`endif

endmodule

/* hw/rtl/pfba_div.sv */
`timescale 1ns / 1ps

module pfba_div
  import pfba_pkg::*;
#(
  parameter int DIVISOR = DEF_PAGE_BYTES
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quot_o
);

  localparam int SHIFT = $clog2(DIVISOR);

  logic             done_q, done_d;
  logic [QUO_W-1:0] quot_q, quot_d;

  always_comb begin
    done_d = start_i;
    quot_d = quot_q;
    if (start_i) begin
      quot_d = QUO_W'(dividend_i >> SHIFT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      quot_q <= '0;
    end else begin
      done_q <= done_d;
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

/* hw/rtl/pfba_map.sv */
`timescale 1ns / 1ps

module pfba_map
  import pfba_pkg::*;
#(
  parameter int WORDS = DEF_FRAME_COUNT / WORD_W,
  parameter int AW    = $clog2(DEF_FRAME_COUNT / WORD_W)
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [WORD_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic [WORD_W-1:0] rd_data_o
);

  logic [WORD_W-1:0] mem_q [WORDS];
  logic [WORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
